// File: src/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper core.
// Used by the front decoder, the command queue and the back end; no dependencies.
`default_nettype none
package cbm_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Bus action codes.
    localparam logic [1:0] ACT_CPU_WRITE = 2'd0;
    localparam logic [1:0] ACT_CPU_READ  = 2'd1;
    localparam logic [1:0] ACT_PPU_READ  = 2'd2;
    localparam logic [1:0] ACT_PPU_WRITE = 2'd3;

    // Mapper variants.
    localparam logic [1:0] VAR_BASE     = 2'd0;
    localparam logic [1:0] VAR_SECURITY = 2'd1;
    localparam logic [1:0] VAR_SWAPPED  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_VARIANT   = 1'b0;
    localparam logic CFG_MIRRORING = 1'b1;

    // PPU target codes.
    localparam logic [1:0] TGT_NONE      = 2'd0;
    localparam logic [1:0] TGT_PATTERN   = 2'd1;
    localparam logic [1:0] TGT_NAMETABLE = 2'd2;

    // Register decode addresses.
    localparam logic [15:0] REG_MASK     = 16'h7300;
    localparam logic [15:0] REG_BANK_LO  = 16'h5000;
    localparam logic [15:0] REG_CONTROL  = 16'h5100;
    localparam logic [15:0] REG_BANK_HI  = 16'h5200;
    localparam logic [15:0] REG_MODE     = 16'h5300;
    localparam logic [15:0] SEC_ADDR     = 16'h5101;
    localparam logic [3:0]  SEC_PAGE     = 4'h5;
    localparam logic [9:0]  ATTR_START   = 10'h3C0;
    localparam logic [13:0] PALETTE_BASE = 14'h3F00;
    localparam logic [2:0]  MODE_OR_BANK = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_BANK_LO,
        OP_CONTROL,
        OP_BANK_HI,
        OP_MODE,
        OP_SEC_WRITE,
        OP_READ_FLAG,
        OP_READ_CTRL,
        OP_PATTERN,
        OP_NAMETABLE
    } op_t;

    // One classified transaction as it travels from front to back.
    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [12:0] addr;
        logic        chr_read;
        logic        sprite;
        logic        latch_en;
        logic        latch_bit;
    } cmd_t;

endpackage
`default_nettype wire

// File: src/cbm_front.sv
// Front end: configuration registers and decode of each bus transaction.
// Depends on cbm_pkg for the command type and the decode constants.
`default_nettype none
module cbm_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_write,
    input  wire logic         cfg_index,
    input  wire logic [1:0]   cfg_data,
    input  wire logic [1:0]   action,
    input  wire logic [15:0]  address,
    input  wire logic [7:0]   write_data,
    input  wire logic         sprite_fetch,
    output cbm_pkg::cmd_t     cmd
);

    logic [1:0] variant_reg;
    logic       vmirror_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= cbm_pkg::VAR_BASE;
            vmirror_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cbm_pkg::CFG_VARIANT:   variant_reg <= cfg_data;
                cbm_pkg::CFG_MIRRORING: vmirror_reg <= cfg_data[0];
            endcase
        end
    end

    logic [15:0] reg_addr;
    logic        nt_bank;

    always_comb
    begin
        if (variant_reg == cbm_pkg::VAR_SWAPPED)
            reg_addr = {1'b0, address[14:12], 2'b00, address[8], address[9], 8'h00};
        else
            reg_addr = address & cbm_pkg::REG_MASK;
        nt_bank = vmirror_reg ? address[10] : address[11];

        cmd           = '0;
        cmd.op        = cbm_pkg::OP_NONE;
        cmd.data      = write_data;
        cmd.chr_read  = (action == cbm_pkg::ACT_PPU_READ);
        cmd.sprite    = sprite_fetch;
        cmd.latch_bit = address[9];

        unique case (action)
            cbm_pkg::ACT_CPU_WRITE:
            begin
                if (variant_reg == cbm_pkg::VAR_SECURITY && address == cbm_pkg::SEC_ADDR)
                    cmd.op = cbm_pkg::OP_SEC_WRITE;
                else if (reg_addr == cbm_pkg::REG_BANK_LO)
                    cmd.op = cbm_pkg::OP_BANK_LO;
                else if (reg_addr == cbm_pkg::REG_CONTROL)
                    cmd.op = cbm_pkg::OP_CONTROL;
                else if (reg_addr == cbm_pkg::REG_BANK_HI)
                    cmd.op = cbm_pkg::OP_BANK_HI;
                else if (reg_addr == cbm_pkg::REG_MODE)
                    cmd.op = cbm_pkg::OP_MODE;
            end
            cbm_pkg::ACT_CPU_READ:
            begin
                if (address[15:12] == cbm_pkg::SEC_PAGE)
                begin
                    if (variant_reg == cbm_pkg::VAR_SECURITY)
                        cmd.op = cbm_pkg::OP_READ_FLAG;
                    else if (variant_reg == cbm_pkg::VAR_SWAPPED)
                        cmd.op = cbm_pkg::OP_READ_CTRL;
                end
            end
            cbm_pkg::ACT_PPU_READ, cbm_pkg::ACT_PPU_WRITE:
            begin
                if (!address[13])
                begin
                    cmd.op   = cbm_pkg::OP_PATTERN;
                    cmd.addr = address[12:0];
                end
                else if (address[13:0] < cbm_pkg::PALETTE_BASE)
                begin
                    cmd.op       = cbm_pkg::OP_NAMETABLE;
                    cmd.addr     = {2'b00, nt_bank, address[9:0]};
                    // Only nametable fetches move the latch, not attribute fetches.
                    cmd.latch_en = cmd.chr_read && (address[9:0] < cbm_pkg::ATTR_START);
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/cbm_queue.sv
// Short command queue between the front decoder and the back end.
// Depends on cbm_pkg for the command type and the queue depth.
`default_nettype none
module cbm_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  cbm_pkg::cmd_t     push_cmd,
    output logic              full,
    input  wire logic         pop,
    output logic              head_valid,
    output cbm_pkg::cmd_t     head_cmd
);

    cbm_pkg::cmd_t                 entry_reg [cbm_pkg::QUEUE_DEPTH];
    logic [cbm_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [cbm_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [cbm_pkg::QCNT_W-1:0]    count_reg,  count_next;

    localparam logic [cbm_pkg::QPTR_W-1:0] LAST = cbm_pkg::QPTR_W'(cbm_pkg::QUEUE_DEPTH - 1);
    localparam logic [cbm_pkg::QCNT_W-1:0] CNT_FULL = cbm_pkg::QCNT_W'(cbm_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

// File: src/cbm_back.sv
// Back end: mapper state, execution of queued commands and the result register.
// Depends on cbm_pkg for the command type and the target codes.
`default_nettype none
module cbm_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         head_valid,
    input  cbm_pkg::cmd_t     head_cmd,
    output logic              pop,
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    output logic [5:0]        prg_bank,
    output logic              cpu_read_hit,
    output logic [7:0]        cpu_read_data,
    output logic [1:0]        ppu_target,
    output logic [12:0]       ppu_mapped_addr
);

    logic [5:0] bank_number_reg,   bank_number_next;
    logic       bank_or_bit_reg,   bank_or_bit_next;
    logic [2:0] bank_mode_reg,     bank_mode_next;
    logic       chr_follow_reg,    chr_follow_next;
    logic       sprites_upper_reg, sprites_upper_next;
    logic       nt_latch_reg,      nt_latch_next;
    logic [7:0] control_copy_reg,  control_copy_next;
    logic [7:0] sec_last_reg,      sec_last_next;
    logic       sec_flag_reg,      sec_flag_next;

    logic        rsp_valid_reg;
    logic [5:0]  prg_bank_reg,   prg_bank_next;
    logic        read_hit_reg,   read_hit_next;
    logic [7:0]  read_data_reg,  read_data_next;
    logic [1:0]  target_reg,     target_next;
    logic [12:0] mapped_reg,     mapped_next;
    logic        half;

    assign pop = head_valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        bank_number_next   = bank_number_reg;
        bank_or_bit_next   = bank_or_bit_reg;
        bank_mode_next     = bank_mode_reg;
        chr_follow_next    = chr_follow_reg;
        sprites_upper_next = sprites_upper_reg;
        nt_latch_next      = nt_latch_reg;
        control_copy_next  = control_copy_reg;
        sec_last_next      = sec_last_reg;
        sec_flag_next      = sec_flag_reg;
        read_hit_next      = 1'b0;
        read_data_next     = 8'h00;
        target_next        = cbm_pkg::TGT_NONE;
        mapped_next        = '0;
        half               = head_cmd.addr[12];

        unique case (head_cmd.op)
            cbm_pkg::OP_BANK_LO:
            begin
                bank_number_next = {bank_number_reg[5:4], head_cmd.data[3:0]};
                chr_follow_next  = head_cmd.data[7];
            end
            cbm_pkg::OP_CONTROL:
            begin
                control_copy_next = head_cmd.data;
                bank_or_bit_next  = head_cmd.data[1];
            end
            cbm_pkg::OP_BANK_HI:
            begin
                bank_number_next   = {head_cmd.data[1:0], bank_number_reg[3:0]};
                sprites_upper_next = head_cmd.data[3];
            end
            cbm_pkg::OP_MODE:
                bank_mode_next = head_cmd.data[2:0];
            cbm_pkg::OP_SEC_WRITE:
            begin
                // The flag flips on a zero write that follows an odd value.
                if (sec_last_reg[0] && head_cmd.data == 8'h00)
                    sec_flag_next = !sec_flag_reg;
                sec_last_next = head_cmd.data;
            end
            cbm_pkg::OP_READ_FLAG:
            begin
                read_hit_next  = 1'b1;
                read_data_next = {5'b00000, sec_flag_reg, 2'b00};
            end
            cbm_pkg::OP_READ_CTRL:
            begin
                read_hit_next  = 1'b1;
                read_data_next = {5'b00000, control_copy_reg[2], 2'b00};
            end
            cbm_pkg::OP_PATTERN:
            begin
                if (head_cmd.chr_read && chr_follow_reg)
                    half = (head_cmd.sprite && sprites_upper_reg) ? 1'b1 : nt_latch_reg;
                target_next = cbm_pkg::TGT_PATTERN;
                mapped_next = {half, head_cmd.addr[11:0]};
            end
            cbm_pkg::OP_NAMETABLE:
            begin
                if (head_cmd.latch_en)
                    nt_latch_next = head_cmd.latch_bit;
                target_next = cbm_pkg::TGT_NAMETABLE;
                mapped_next = head_cmd.addr;
            end
            default:
            begin
            end
        endcase

        prg_bank_next = bank_number_next;
        if (bank_mode_next == cbm_pkg::MODE_OR_BANK)
            prg_bank_next[0] = bank_number_next[0] | bank_or_bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_number_reg   <= 6'd3;
            bank_or_bit_reg   <= 1'b0;
            bank_mode_reg     <= 3'd7;
            chr_follow_reg    <= 1'b0;
            sprites_upper_reg <= 1'b0;
            nt_latch_reg      <= 1'b0;
            control_copy_reg  <= 8'h00;
            sec_last_reg      <= 8'h01;
            sec_flag_reg      <= 1'b1;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                bank_number_reg   <= bank_number_next;
                bank_or_bit_reg   <= bank_or_bit_next;
                bank_mode_reg     <= bank_mode_next;
                chr_follow_reg    <= chr_follow_next;
                sprites_upper_reg <= sprites_upper_next;
                nt_latch_reg      <= nt_latch_next;
                control_copy_reg  <= control_copy_next;
                sec_last_reg      <= sec_last_next;
                sec_flag_reg      <= sec_flag_next;
            end
            if (pop)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prg_bank_reg  <= prg_bank_next;
            read_hit_reg  <= read_hit_next;
            read_data_reg <= read_data_next;
            target_reg    <= target_next;
            mapped_reg    <= mapped_next;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign prg_bank        = prg_bank_reg;
    assign cpu_read_hit    = read_hit_reg;
    assign cpu_read_data   = read_data_reg;
    assign ppu_target      = target_reg;
    assign ppu_mapped_addr = mapped_reg;

endmodule
`default_nettype wire

// File: src/cartridge_bank_mapper_with_nt_latch_core.sv
// Top level of the cartridge bank mapper with nametable latch.
// Depends on cbm_pkg, cbm_front, cbm_queue and cbm_back.
`default_nettype none
// The core translates one CPU or PPU bus transaction per cycle unless
// stalled and returns exactly one result transaction for each, in order. A
// request is taken at an edge with req_valid high and req_stall low; its
// result, registered when the back end pops it, stays on the rsp_* ports until
// rsp_stall is low. The sustained rate is one transaction per cycle, set by
// the back end, which updates the mapper state for one command each
// unstalled cycle. A two-entry queue lets the request side keep going while
// a result waits: req_stall rises only when it is full. Configuration
// (mapper variant, mirroring) is written through cfg_valid/cfg_ready, ready
// is always high, and it must only change while the core is idle.
module cartridge_bank_mapper_with_nt_latch_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Configuration write channel.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [1:0]   cfg_data,
    // Request channel.
    input  wire logic         req_valid,
    output logic              req_stall,
    input  wire logic [1:0]   action,
    input  wire logic [15:0]  address,
    input  wire logic [7:0]   write_data,
    input  wire logic         sprite_fetch,
    // Result channel.
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    output logic [5:0]        prg_bank,
    output logic              cpu_read_hit,
    output logic [7:0]        cpu_read_data,
    output logic [1:0]        ppu_target,
    output logic [12:0]       ppu_mapped_addr
);

    cbm_pkg::cmd_t front_cmd;
    cbm_pkg::cmd_t head_cmd;
    logic          queue_full;
    logic          head_valid;
    logic          pop;
    logic          push;

    // Configuration writes never wait.
    assign cfg_ready = 1'b1;

    // A request transaction is accepted whenever the queue has room.
    assign req_stall = queue_full;
    assign push      = req_valid && !queue_full;

    // The front end holds the configuration and classifies each request.
    cbm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .address      (address),
        .write_data   (write_data),
        .sprite_fetch (sprite_fetch),
        .cmd          (front_cmd)
    );

    cbm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (front_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // The back end owns all mapper state and the result register.
    cbm_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .prg_bank        (prg_bank),
        .cpu_read_hit    (cpu_read_hit),
        .cpu_read_data   (cpu_read_data),
        .ppu_target      (ppu_target),
        .ppu_mapped_addr (ppu_mapped_addr)
    );

endmodule
`default_nettype wire

// File: src/cbm_checker.sv
// Port-level checks for the mapper core, attached with a bind statement.
// Depends on the top-level ports of cartridge_bank_mapper_with_nt_latch_core and cbm_pkg.
`default_nettype none
module cbm_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         rsp_valid,
    input wire logic         rsp_stall,
    input wire logic [5:0]   prg_bank,
    input wire logic         cpu_read_hit,
    input wire logic [7:0]   cpu_read_data,
    input wire logic [1:0]   ppu_target,
    input wire logic [12:0]  ppu_mapped_addr
);

    // A stalled result transaction stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its bank and address.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(prg_bank) && $stable(ppu_mapped_addr))
        else $error("result payload changed while stalled");

    // A security hit only comes from a CPU read, never with a PPU target.
    a_hit_no_ppu: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && cpu_read_hit |-> ppu_target == cbm_pkg::TGT_NONE
                                      && ppu_mapped_addr == 13'd0)
        else $error("security hit with a PPU mapping");

    // Read data is zero without a hit, and zero or four with one.
    a_read_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (cpu_read_hit ? (cpu_read_data == 8'd0 || cpu_read_data == 8'd4)
                                    : (cpu_read_data == 8'd0)))
        else $error("bad security read data");

    // Nametable RAM is 2 KB, so its addresses never reach bit 11.
    a_nt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ppu_target == cbm_pkg::TGT_NAMETABLE |-> ppu_mapped_addr[12:11] == 2'b00)
        else $error("nametable address out of range");

endmodule

bind cartridge_bank_mapper_with_nt_latch_core cbm_checker u_cbm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .prg_bank        (prg_bank),
    .cpu_read_hit    (cpu_read_hit),
    .cpu_read_data   (cpu_read_data),
    .ppu_target      (ppu_target),
    .ppu_mapped_addr (ppu_mapped_addr)
);
`default_nettype wire
